[design/swap_slot_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Swap slot allocator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SWAP_SLOT_ALLOCATOR_DEFINES_SVH
`define SWAP_SLOT_ALLOCATOR_DEFINES_SVH

// Expression holds at every clock edge outside reset.
`define SSA_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SSA_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/ssa_pkg.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Pool size, field widths, request and status codes, queued item type.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    localparam int REQ_W      = 2;
    localparam int OWNER_W    = 16;
    localparam int PAGE_W     = 52;
    localparam int IDX_W      = 16;
    localparam int LAT_W      = 16;
    localparam int TOT_W      = 32;
    localparam int OUT_SLOT_W = 10;
    localparam int OUT_CNT_W  = 11;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [IDX_W:0]   SLOTS_IDX = (IDX_W + 1)'(SLOTS);
    localparam logic [LAT_W-1:0] LATENCY_RESET = LAT_W'(5000);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_FREE     = 2'd1,
        REQ_SWAP_OUT = 2'd2,
        REQ_SWAP_IN  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_USED  = 2'd3
    } status_t;

    typedef struct packed {
        req_t               op;
        logic               range_err;
        logic [SLOT_W-1:0]  slot;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
    } item_t;

endpackage

`default_nettype wire

[design/swap_slot_allocator.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator
// Hands out and reclaims swap slots from a LIFO free stack and counts swap
// transfers.
//
//   Channel   Handshake              Payload
//   req       req_valid/req_stall    req_type, owner_id, page_number,
//                                    slot_index
//   rsp       rsp_valid/rsp_stall    status, slot_out, latency_us,
//                                    used_count, free_count,
//                                    swap_out_total, swap_in_total
//   cfg       cfg_wr_en              cfg_wr_data (io latency)
//
// The back end reads the free stack and slot use table as it takes a request,
// then applies the request and writes them back before it takes the next one.
// A two-entry queue takes requests while the back end is busy.
// Reset needs no clearing pass; the stack low water mark stands in for the
// initial stack and use table contents.
// A stalled result holds in the output register; the back end then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_slot_allocator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ssa_pkg::LAT_W-1:0]       cfg_wr_data,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [ssa_pkg::REQ_W-1:0]       req_type,
    input  wire logic [ssa_pkg::OWNER_W-1:0]     owner_id,
    input  wire logic [ssa_pkg::PAGE_W-1:0]      page_number,
    input  wire logic [ssa_pkg::IDX_W-1:0]       slot_index,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic [1:0]                           status,
    output logic [ssa_pkg::OUT_SLOT_W-1:0]       slot_out,
    output logic [ssa_pkg::LAT_W-1:0]            latency_us,
    output logic [ssa_pkg::OUT_CNT_W-1:0]        used_count,
    output logic [ssa_pkg::OUT_CNT_W-1:0]        free_count,
    output logic [ssa_pkg::TOT_W-1:0]            swap_out_total,
    output logic [ssa_pkg::TOT_W-1:0]            swap_in_total
);

    logic           q_valid;
    ssa_pkg::item_t q_item;
    logic           q_pop;

    ssa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .owner_id    (owner_id),
        .page_number (page_number),
        .slot_index  (slot_index),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    ssa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .slot_out       (slot_out),
        .latency_us     (latency_us),
        .used_count     (used_count),
        .free_count     (free_count),
        .swap_out_total (swap_out_total),
        .swap_in_total  (swap_in_total)
    );

endmodule

`default_nettype wire

[design/ssa_front.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator front end
// Accepts requests, decodes the type and range check, queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "swap_slot_allocator_defines.svh"

module ssa_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [ssa_pkg::REQ_W-1:0]   req_type,
    input  wire logic [ssa_pkg::OWNER_W-1:0] owner_id,
    input  wire logic [ssa_pkg::PAGE_W-1:0]  page_number,
    input  wire logic [ssa_pkg::IDX_W-1:0]   slot_index,
    output logic                             q_valid,
    output ssa_pkg::item_t                   q_item,
    input  wire logic                        q_pop
);

    ssa_pkg::item_t              q_mem [ssa_pkg::QDEPTH];
    ssa_pkg::item_t              new_item;
    logic [ssa_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ssa_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ssa_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        push;
    logic                        pop;

    always_comb
    begin
        new_item.op        = ssa_pkg::req_t'(req_type);
        new_item.range_err = ({1'b0, slot_index} >= ssa_pkg::SLOTS_IDX);
        new_item.slot      = ssa_pkg::SLOT_W'(slot_index);
        new_item.owner     = owner_id;
        new_item.page      = page_number;
    end

    assign req_stall = (cnt_reg == ssa_pkg::QCNT_W'(ssa_pkg::QDEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (cnt_reg != '0);
    assign pop       = q_valid && q_pop;
    assign q_item    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `SSA_ASSERT_ALWAYS(a_queue_bound, cnt_reg <= ssa_pkg::QCNT_W'(ssa_pkg::QDEPTH), "queue overfilled")

endmodule

`default_nettype wire

[design/ssa_back.sv]
// ----------------------------------------------------------------------------
// Swap slot allocator back end
// Reads the free stack and slot use table, then applies the request, writes
// the tables and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "swap_slot_allocator_defines.svh"

module ssa_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ssa_pkg::LAT_W-1:0]      cfg_wr_data,
    input  wire logic                           q_valid,
    input  wire ssa_pkg::item_t                 q_item,
    output logic                                q_pop,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic [1:0]                          status,
    output logic [ssa_pkg::OUT_SLOT_W-1:0]      slot_out,
    output logic [ssa_pkg::LAT_W-1:0]           latency_us,
    output logic [ssa_pkg::OUT_CNT_W-1:0]       used_count,
    output logic [ssa_pkg::OUT_CNT_W-1:0]       free_count,
    output logic [ssa_pkg::TOT_W-1:0]           swap_out_total,
    output logic [ssa_pkg::TOT_W-1:0]           swap_in_total
);

    typedef enum logic {
        PH_IDLE,
        PH_EXEC
    } phase_t;

    logic [ssa_pkg::SLOT_W-1:0]  stack_mem   [ssa_pkg::SLOTS];
    logic                        use_mem     [ssa_pkg::SLOTS];
    logic [ssa_pkg::OWNER_W-1:0] owner_mem   [ssa_pkg::SLOTS];
    logic [ssa_pkg::PAGE_W-1:0]  page_mem    [ssa_pkg::SLOTS];

    phase_t                      phase_reg, phase_next;
    ssa_pkg::item_t              item_reg;
    logic [ssa_pkg::CNT_W-1:0]   top_reg, top_next;
    logic [ssa_pkg::CNT_W-1:0]   lw_reg, lw_next;
    logic [ssa_pkg::CNT_W-1:0]   used_reg, used_next;
    logic [ssa_pkg::TOT_W-1:0]   out_tot_reg, out_tot_next;
    logic [ssa_pkg::TOT_W-1:0]   in_tot_reg, in_tot_next;
    logic [ssa_pkg::LAT_W-1:0]   lat_cfg_reg;
    logic [ssa_pkg::SLOT_W-1:0]  stack_rd_reg;
    logic                        use_rd_reg;

    logic                        rsp_valid_reg;
    ssa_pkg::status_t            status_reg, status_next;
    logic [ssa_pkg::OUT_SLOT_W-1:0] slot_out_reg;
    logic [ssa_pkg::LAT_W-1:0]   lat_out_reg, lat_out_next;
    logic [ssa_pkg::OUT_CNT_W-1:0] used_out_reg;
    logic [ssa_pkg::OUT_CNT_W-1:0] free_out_reg;
    logic [ssa_pkg::TOT_W-1:0]   out_tot_out_reg;
    logic [ssa_pkg::TOT_W-1:0]   in_tot_out_reg;

    logic [ssa_pkg::CNT_W-1:0]   pop_pos;
    logic [ssa_pkg::SLOT_W-1:0]  rd_idx;
    logic                        fresh;
    logic [ssa_pkg::SLOT_W-1:0]  popped;
    logic                        slot_used;
    logic [ssa_pkg::SLOT_W-1:0]  grant;
    logic                        exec_go;
    logic                        stack_we;
    logic                        use_we;
    logic                        use_wdata;
    logic [ssa_pkg::SLOT_W-1:0]  use_addr;
    logic                        info_we;
    logic [ssa_pkg::CNT_W:0]     pool_sum;

    assign q_pop   = (phase_reg == PH_IDLE) && q_valid;
    assign exec_go = (phase_reg == PH_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign pop_pos = top_reg - ssa_pkg::CNT_W'(1);
    assign rd_idx  = pop_pos[ssa_pkg::SLOT_W-1:0];
    assign fresh   = (pop_pos < lw_reg);
    assign popped  = fresh ? pop_pos[ssa_pkg::SLOT_W-1:0] : stack_rd_reg;
    assign slot_used = (ssa_pkg::CNT_W'(item_reg.slot) >= lw_reg) ? use_rd_reg : 1'b0;
    assign pool_sum  = {1'b0, top_reg} + {1'b0, used_reg};

    always_comb
    begin
        status_next  = ssa_pkg::ST_OK;
        grant        = '0;
        lat_out_next = '0;
        top_next     = top_reg;
        lw_next      = lw_reg;
        used_next    = used_reg;
        out_tot_next = out_tot_reg;
        in_tot_next  = in_tot_reg;
        stack_we     = 1'b0;
        use_we       = 1'b0;
        use_wdata    = 1'b0;
        use_addr     = item_reg.slot;
        info_we      = 1'b0;
        unique case (item_reg.op)
            ssa_pkg::REQ_ALLOC:
            begin
                if (top_reg == '0)
                begin
                    status_next = ssa_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    top_next  = pop_pos;
                    lw_next   = fresh ? pop_pos : lw_reg;
                    use_we    = 1'b1;
                    use_wdata = 1'b1;
                    use_addr  = popped;
                    info_we   = 1'b1;
                    used_next = used_reg + 1'b1;
                    grant     = popped;
                end
            end
            ssa_pkg::REQ_FREE:
            begin
                if (item_reg.range_err)
                begin
                    status_next = ssa_pkg::ST_RANGE;
                end
                else if (!slot_used)
                begin
                    status_next = ssa_pkg::ST_NOT_USED;
                end
                else
                begin
                    use_we = 1'b1;
                    if (top_reg < ssa_pkg::SLOTS_CNT)
                    begin
                        stack_we = 1'b1;
                        top_next = top_reg + 1'b1;
                    end
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            ssa_pkg::REQ_SWAP_OUT:
            begin
                if (item_reg.range_err)
                begin
                    status_next = ssa_pkg::ST_RANGE;
                end
                else
                begin
                    out_tot_next = out_tot_reg + 1'b1;
                    lat_out_next = lat_cfg_reg;
                end
            end
            ssa_pkg::REQ_SWAP_IN:
            begin
                if (item_reg.range_err)
                begin
                    status_next = ssa_pkg::ST_RANGE;
                end
                else
                begin
                    in_tot_next  = in_tot_reg + 1'b1;
                    lat_out_next = lat_cfg_reg;
                end
            end
            default:
            begin
                status_next = ssa_pkg::ST_OK;
            end
        endcase
    end

    // Free stack: read the entry below the top, push a released slot.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            stack_rd_reg <= stack_mem[rd_idx];
        end
        if (exec_go && stack_we)
        begin
            stack_mem[top_reg[ssa_pkg::SLOT_W-1:0]] <= item_reg.slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            use_rd_reg <= use_mem[q_item.slot];
        end
        if (exec_go && use_we)
        begin
            use_mem[use_addr] <= use_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && info_we)
        begin
            owner_mem[popped] <= item_reg.owner;
            page_mem[popped]  <= item_reg.page;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (q_pop)
                begin
                    phase_next = PH_EXEC;
                end
            end
            PH_EXEC:
            begin
                if (exec_go)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            item_reg        <= '0;
            top_reg         <= ssa_pkg::SLOTS_CNT;
            lw_reg          <= ssa_pkg::SLOTS_CNT;
            used_reg        <= '0;
            out_tot_reg     <= '0;
            in_tot_reg      <= '0;
            lat_cfg_reg     <= ssa_pkg::LATENCY_RESET;
            rsp_valid_reg   <= 1'b0;
            status_reg      <= ssa_pkg::ST_OK;
            slot_out_reg    <= '0;
            lat_out_reg     <= '0;
            used_out_reg    <= '0;
            free_out_reg    <= '0;
            out_tot_out_reg <= '0;
            in_tot_out_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cfg_wr_en)
            begin
                lat_cfg_reg <= cfg_wr_data;
            end
            if (q_pop)
            begin
                item_reg <= q_item;
            end
            if (exec_go)
            begin
                top_reg         <= top_next;
                lw_reg          <= lw_next;
                used_reg        <= used_next;
                out_tot_reg     <= out_tot_next;
                in_tot_reg      <= in_tot_next;
                rsp_valid_reg   <= 1'b1;
                status_reg      <= status_next;
                slot_out_reg    <= ssa_pkg::OUT_SLOT_W'(grant);
                lat_out_reg     <= lat_out_next;
                used_out_reg    <= ssa_pkg::OUT_CNT_W'(used_next);
                free_out_reg    <= ssa_pkg::OUT_CNT_W'(ssa_pkg::SLOTS_CNT - used_next);
                out_tot_out_reg <= out_tot_next;
                in_tot_out_reg  <= in_tot_next;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign slot_out       = slot_out_reg;
    assign latency_us     = lat_out_reg;
    assign used_count     = used_out_reg;
    assign free_count     = free_out_reg;
    assign swap_out_total = out_tot_out_reg;
    assign swap_in_total  = in_tot_out_reg;

    `SSA_ASSERT_ALWAYS(a_pool_conserved, pool_sum == {1'b0, ssa_pkg::SLOTS_CNT}, "pool size lost")
    `SSA_ASSERT_ALWAYS(a_low_water_below_top, lw_reg <= top_reg, "low water mark above stack top")
    `SSA_ASSERT_IMPLY(a_rsp_after_exec, $rose(rsp_valid_reg), $past(exec_go), "result without execute")

endmodule

`default_nettype wire
